>>> hw/rtl/wes1d_pkg.sv
// constants, codes and helpers for the 1d wave equation stencil block
package wes1d_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int NUM_BUFS   = 3;
	localparam int IDX_W      = 10;
	localparam int BUF_W      = 2;
	localparam int MEM_DEPTH  = NUM_BUFS * MAX_POINTS;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int VAL_W      = 32;
	localparam int PC_W       = 11;
	localparam int STEP_W     = 16;
	localparam int COEFF_W    = 16;

	localparam int S_TDATA_W  = ((IDX_W + VAL_W + 7) / 8) * 8;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = ((VAL_W + IDX_W + 7) / 8) * 8;
	localparam int M_TUSER_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PC_W-1:0]    PC_RESET    = PC_W'(1024);
	localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(9830);

	typedef enum logic [1:0] {
		ACT_LOAD_PREV = 2'd0,
		ACT_LOAD_CUR  = 2'd1,
		ACT_RUN       = 2'd2,
		ACT_READ      = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POINT_COUNT = 2'd0,
		CFG_STEP_COUNT  = 2'd1,
		CFG_WAVE_COEFF  = 2'd2
	} cfg_reg_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ISSUE = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_EDGE0 = 6'b001000,
		ST_EDGE1 = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	// buffer number plus k, modulo three
	function automatic logic [BUF_W-1:0] rot_add(input logic [BUF_W-1:0] r,
			input logic [BUF_W-1:0] k);
		logic [BUF_W:0] s;
		s = {1'b0, r} + {1'b0, k};
		if (s >= (BUF_W+1)'(NUM_BUFS))
			s = s - (BUF_W+1)'(NUM_BUFS);
		return s[BUF_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [BUF_W-1:0] b,
			input logic [IDX_W-1:0] i);
		return ADDR_W'(b) * ADDR_W'(MAX_POINTS) + ADDR_W'(i);
	endfunction

endpackage

>>> hw/rtl/wave_equation_stencil_1d.sv
// 1d wave equation stencil: wave buffers in one memory, load, run and read sequencer
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tuser: action; tdata: point_index, sample_value
//  m_axis    out  m_axis_tvalid/tready    tuser: run_done, saturated; tdata: value, index
//  cfg       in   cfg_we                  cfg_index, cfg_data
//
// load and read items go one per cycle unless the output stalls; read data is registered
// twice on its way out. a run makes step_count steps; each step is one pass over the clamped
// point count in memory (two read ports, one write port) plus pipeline drain and edge writes.
// reset clears control state only; the wave memory holds nothing defined until loaded.
// a stalled output holds one result and one more read in flight, then input ready drops.
// no item is taken while a run is in progress.
module wave_equation_stencil_1d (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [wes1d_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // point_index, sample_value, pad
	input  logic [wes1d_pkg::S_TUSER_W-1:0]     s_axis_tuser,  // action
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [wes1d_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // result_value, result_index, pad
	output logic [wes1d_pkg::M_TUSER_W-1:0]     m_axis_tuser,  // run_done, saturated
	input  logic                                cfg_we,
	input  logic [wes1d_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wes1d_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wes1d_pkg::*;

	// configuration
	logic [PC_W-1:0]    point_count_q;
	logic [STEP_W-1:0]  step_count_q;
	logic [COEFF_W-1:0] coeff_q;

	// control
	state_t            state_q;
	logic [BUF_W-1:0]  rot_q;
	logic              ovf_q;
	logic [STEP_W-1:0] steps_left_q;
	logic [IDX_W-1:0]  n_last_q;
	logic [IDX_W-1:0]  j_q;
	logic [1:0]        drain_q;

	// input fields
	action_t           in_action;
	logic [IDX_W-1:0]  in_index;
	logic [VAL_W-1:0]  in_value;
	logic              in_accept;

	// memory
	logic [VAL_W-1:0]  wave_mem [0:MEM_DEPTH-1];
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [VAL_W-1:0]  wd;
	logic              re_a;
	logic              re_b;
	logic [ADDR_W-1:0] ra_a;
	logic [ADDR_W-1:0] ra_b;
	logic [VAL_W-1:0]  rd_a_q;
	logic [VAL_W-1:0]  rd_b_q;

	// buffer roles
	logic [BUF_W-1:0]  buf_old;
	logic [BUF_W-1:0]  buf_cur;
	logic [BUF_W-1:0]  buf_nxt;

	// stencil pipeline
	logic                     win_s1;
	logic                     v_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic signed [VAL_W-1:0]  w0_q;
	logic signed [VAL_W-1:0]  w1_q;
	logic signed [VAL_W+1:0]  lap_c;
	logic signed [VAL_W+1:0]  base_c;
	logic                     v_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic signed [VAL_W+1:0]  lap_s2;
	logic signed [VAL_W+1:0]  base_s2;
	logic                     v_s3;
	logic [IDX_W-1:0]         idx_s3;
	logic signed [50:0]       prod_c;
	logic signed [50:0]       prod_s3;
	logic signed [VAL_W+1:0]  base_s3;
	logic signed [50:0]       rnd_c;
	logic signed [34:0]       rounded_c;
	logic signed [35:0]       sum_c;
	logic [VAL_W-1:0]         sat_val;
	logic                     sat_hit;

	// read and output
	logic              rd_pend_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              out_free;
	logic              out_vld_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [IDX_W-1:0]  out_index_q;
	logic              out_done_q;
	logic              out_sat_q;

	logic              is_idle;
	logic              is_issue;

	assign in_action = action_t'(s_axis_tuser[1:0]);
	assign in_index  = s_axis_tdata[IDX_W-1:0];
	assign in_value  = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];

	assign is_idle  = (state_q == ST_IDLE);
	assign is_issue = (state_q == ST_ISSUE);
	assign out_free = !out_vld_q || m_axis_tready;

	assign s_axis_tready = is_idle && (!rd_pend_q || out_free);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign buf_old = rot_q;
	assign buf_cur = rot_add(rot_q, BUF_W'(1));
	assign buf_nxt = rot_add(rot_q, BUF_W'(2));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= PC_RESET;
			step_count_q  <= '0;
			coeff_q       <= COEFF_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_POINT_COUNT: point_count_q <= cfg_data[PC_W-1:0];
				CFG_STEP_COUNT:  step_count_q  <= cfg_data[STEP_W-1:0];
				CFG_WAVE_COEFF:  coeff_q       <= cfg_data[COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	// memory port control
	always_comb begin
		we = 1'b0;
		wa = mem_addr(buf_nxt, idx_s3);
		wd = sat_val;
		if (v_s3) begin
			we = 1'b1;
		end else if (state_q == ST_EDGE0) begin
			we = 1'b1;
			wa = mem_addr(buf_nxt, '0);
			wd = '0;
		end else if (state_q == ST_EDGE1) begin
			we = 1'b1;
			wa = mem_addr(buf_nxt, n_last_q);
			wd = '0;
		end else if (in_accept && (in_action == ACT_LOAD_PREV)) begin
			we = 1'b1;
			wa = mem_addr(buf_old, in_index);
			wd = in_value;
		end else if (in_accept && (in_action == ACT_LOAD_CUR)) begin
			we = 1'b1;
			wa = mem_addr(buf_cur, in_index);
			wd = in_value;
		end
	end

	assign re_a = is_issue || (in_accept && (in_action == ACT_READ));
	assign ra_a = is_issue ? mem_addr(buf_cur, j_q) : mem_addr(buf_cur, in_index);
	assign re_b = is_issue;
	assign ra_b = mem_addr(buf_old, j_q - IDX_W'(1));

	always_ff @(posedge clk) begin
		if (we)
			wave_mem[wa] <= wd;
		if (re_a)
			rd_a_q <= wave_mem[ra_a];
		if (re_b)
			rd_b_q <= wave_mem[ra_b];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rot_q        <= '0;
			ovf_q        <= 1'b0;
			steps_left_q <= '0;
			n_last_q     <= '0;
			j_q          <= '0;
			drain_q      <= '0;
		end else begin
			if (v_s3 && sat_hit)
				ovf_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (in_action == ACT_RUN)) begin
						ovf_q        <= 1'b0;
						steps_left_q <= step_count_q;
						j_q          <= '0;
						if (point_count_q < PC_W'(3))
							n_last_q <= IDX_W'(2);
						else if (point_count_q > PC_W'(MAX_POINTS))
							n_last_q <= IDX_W'(MAX_POINTS - 1);
						else
							n_last_q <= IDX_W'(point_count_q - PC_W'(1));
						state_q <= (step_count_q == '0) ? ST_DONE : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					j_q <= j_q + IDX_W'(1);
					if (j_q == n_last_q) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2)
						state_q <= ST_EDGE0;
				end
				ST_EDGE0: state_q <= ST_EDGE1;
				ST_EDGE1: begin
					rot_q        <= rot_add(rot_q, BUF_W'(1));
					steps_left_q <= steps_left_q - STEP_W'(1);
					j_q          <= '0;
					state_q      <= (steps_left_q == STEP_W'(1)) ? ST_DONE : ST_ISSUE;
				end
				ST_DONE: begin
					if (out_free && !rd_pend_q)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stencil pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_s1 <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			win_s1 <= is_issue;
			v_s1   <= is_issue && (j_q >= IDX_W'(2));
			v_s2   <= v_s1;
			v_s3   <= v_s2;
		end
	end

	// s1: window of cur[i-1], cur[i], with cur[i+1] and old[i] from memory
	assign lap_c  = (VAL_W+2)'(w0_q) - ((VAL_W+2)'(w1_q) <<< 1) + (VAL_W+2)'($signed(rd_a_q));
	assign base_c = ((VAL_W+2)'(w1_q) <<< 1) - (VAL_W+2)'($signed(rd_b_q));

	// s2: coefficient product; s3: round, accumulate, saturate
	assign prod_c    = 51'(lap_s2) * 51'($signed({1'b0, coeff_q}));
	assign rnd_c     = prod_s3 + 51'sd32768;
	assign rounded_c = rnd_c[50:16];
	assign sum_c     = 36'(base_s3) + 36'(rounded_c);

	always_comb begin
		sat_hit = 1'b0;
		sat_val = sum_c[VAL_W-1:0];
		if (sum_c > 36'sh07FFFFFFF) begin
			sat_hit = 1'b1;
			sat_val = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (sum_c < -36'sh080000000) begin
			sat_hit = 1'b1;
			sat_val = {1'b1, {(VAL_W-1){1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= j_q - IDX_W'(1);
		if (win_s1) begin
			w0_q <= w1_q;
			w1_q <= $signed(rd_a_q);
		end
		lap_s2  <= lap_c;
		base_s2 <= base_c;
		idx_s2  <= idx_s1;
		prod_s3 <= prod_c;
		base_s3 <= base_s2;
		idx_s3  <= idx_s2;
	end

	// read in flight and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_accept && (in_action == ACT_READ))
				rd_pend_q <= 1'b1;
			else if (out_free)
				rd_pend_q <= 1'b0;
			if (out_free)
				out_vld_q <= rd_pend_q || (state_q == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && (in_action == ACT_READ))
			rd_idx_q <= in_index;
		if (out_free) begin
			if (rd_pend_q) begin
				out_value_q <= rd_a_q;
				out_index_q <= rd_idx_q;
				out_done_q  <= 1'b0;
				out_sat_q   <= ovf_q;
			end else begin
				out_value_q <= '0;
				out_index_q <= '0;
				out_done_q  <= 1'b1;
				out_sat_q   <= ovf_q;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = M_TDATA_W'({out_index_q, out_value_q});
	assign m_axis_tuser  = {out_sat_q, out_done_q};

endmodule
